>>> sv/vcfc_pkg.sv
// shared types, constants and the face corner table of the voxel face culler
`default_nettype none
package vcfc_pkg;

	localparam int CHUNK_SIDE_DEF = 16;
	localparam int COORD_W        = 4;
	localparam int OP_W           = 2;
	localparam int ORD_W          = 13;
	localparam int INDEX_W        = 17;
	localparam int FACES          = 6;
	localparam int CORNERS        = 6;
	localparam int CORNER_W       = 5;
	localparam int FACE_W         = 3;
	localparam int IN_DATA_W      = 16;
	localparam int OUT_DATA_W     = 24;

	// face codes in emission order
	localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
	localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
	localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd4;
	localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd5;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 2'd0,
		OP_MESH    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CENTER,
		ST_PROBE,
		ST_LAST,
		ST_HAND
	} state_t;

	// one solid voxel handed from the probe sequencer to the index emitter
	typedef struct packed {
		logic [FACES-1:0] face_open;
		logic [ORD_W-1:0] ordinal;
	} job_t;

	// corner offset of corner k of a face, already including the face base
	function automatic logic [CORNER_W-1:0] corner_off(input logic [FACE_W-1:0] face,
		input logic [FACE_W-1:0] k);
		logic [CORNERS-1:0][CORNER_W-1:0] row;
		row = '0;
		case (face)
			FACE_FRONT:  row = {5'd2,  5'd3,  5'd1,  5'd2,  5'd1,  5'd0};
			FACE_BACK:   row = {5'd7,  5'd6,  5'd5,  5'd5,  5'd6,  5'd4};
			FACE_TOP:    row = {5'd10, 5'd11, 5'd9,  5'd10, 5'd9,  5'd8};
			FACE_BOTTOM: row = {5'd15, 5'd14, 5'd13, 5'd13, 5'd14, 5'd12};
			FACE_LEFT:   row = {5'd18, 5'd19, 5'd17, 5'd18, 5'd17, 5'd16};
			FACE_RIGHT:  row = {5'd23, 5'd22, 5'd21, 5'd21, 5'd22, 5'd20};
			default:     row = '0;
		endcase
		return row[k];
	endfunction

endpackage
`default_nettype wire

>>> sv/vcfc_occ_mem.sv
// occupancy memory: one flag per voxel, one write and one registered read port
`default_nettype none
module vcfc_occ_mem #(
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic               rd_data
);

	logic mem_q [0:(1<<AW)-1];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

>>> sv/vcfc_ctrl.sv
// sequencer: clearing pass, voxel writes, center and neighbor probes, ordinal
`default_nettype none
module vcfc_ctrl #(
	parameter int CHUNK_SIDE = vcfc_pkg::CHUNK_SIDE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [vcfc_pkg::OP_W-1:0]           in_op,
	input  wire logic [vcfc_pkg::COORD_W-1:0]        in_x,
	input  wire logic [vcfc_pkg::COORD_W-1:0]        in_y,
	input  wire logic [vcfc_pkg::COORD_W-1:0]        in_z,
	input  wire logic                                in_solid,
	output logic                                     job_valid,
	output vcfc_pkg::job_t                           job,
	input  wire logic                                job_ready,
	output logic                                     mem_we,
	output logic [3*$clog2(CHUNK_SIDE)-1:0]          mem_waddr,
	output logic                                     mem_wdata,
	output logic [3*$clog2(CHUNK_SIDE)-1:0]          mem_raddr,
	input  wire logic                                mem_rdata
);

	localparam int CW = $clog2(CHUNK_SIDE);
	localparam int AW = 3 * CW;
	localparam logic [CW-1:0] CMAX = CW'(CHUNK_SIDE - 1);

	vcfc_pkg::state_t state_q, state_d;

	logic [AW-1:0]                   clr_addr_q;
	logic [CW-1:0]                   x_q, y_q, z_q;
	logic [vcfc_pkg::FACE_W-1:0]     face_q;
	logic                            pend_q;
	logic [vcfc_pkg::FACE_W-1:0]     pend_face_q;
	logic                            pend_edge_q;
	logic [vcfc_pkg::FACES-1:0]      mask_q;
	logic [vcfc_pkg::ORD_W-1:0]      ordinal_q;

	logic                            accept;
	logic                            in_chunk;
	logic [CW-1:0]                   ix, iy, iz;
	logic                            nb_edge;
	logic [AW-1:0]                   nb_addr;
	vcfc_pkg::op_t                   op;

	assign op     = vcfc_pkg::op_t'(in_op);
	assign accept = in_valid && in_ready;
	assign in_chunk = (32'(in_x) < CHUNK_SIDE) && (32'(in_y) < CHUNK_SIDE)
		&& (32'(in_z) < CHUNK_SIDE);
	assign ix = CW'(in_x);
	assign iy = CW'(in_y);
	assign iz = CW'(in_z);

	// neighbor of the face under probe; edge faces are open whatever the read returns
	always_comb begin
		nb_edge = 1'b0;
		nb_addr = {z_q, y_q, x_q};
		case (face_q)
			vcfc_pkg::FACE_FRONT: begin
				nb_edge = (z_q == CMAX);
				nb_addr = {z_q + 1'b1, y_q, x_q};
			end
			vcfc_pkg::FACE_BACK: begin
				nb_edge = (z_q == '0);
				nb_addr = {z_q - 1'b1, y_q, x_q};
			end
			vcfc_pkg::FACE_TOP: begin
				nb_edge = (y_q == CMAX);
				nb_addr = {z_q, y_q + 1'b1, x_q};
			end
			vcfc_pkg::FACE_BOTTOM: begin
				nb_edge = (y_q == '0);
				nb_addr = {z_q, y_q - 1'b1, x_q};
			end
			vcfc_pkg::FACE_LEFT: begin
				nb_edge = (x_q == '0);
				nb_addr = {z_q, y_q, x_q - 1'b1};
			end
			vcfc_pkg::FACE_RIGHT: begin
				nb_edge = (x_q == CMAX);
				nb_addr = {z_q, y_q, x_q + 1'b1};
			end
			default: begin
				nb_edge = 1'b1;
				nb_addr = {z_q, y_q, x_q};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vcfc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		job_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {iz, iy, ix};
		mem_wdata = in_solid;
		mem_raddr = nb_addr;
		case (state_q)
			vcfc_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = 1'b0;
				if (clr_addr_q == '1) begin
					state_d = vcfc_pkg::ST_IDLE;
				end
			end
			vcfc_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				mem_raddr = {iz, iy, ix};
				if (accept && in_chunk) begin
					if (op == vcfc_pkg::OP_WRITE) begin
						mem_we = 1'b1;
					end else if (op == vcfc_pkg::OP_MESH) begin
						state_d = vcfc_pkg::ST_CENTER;
					end
				end
			end
			vcfc_pkg::ST_CENTER: begin
				state_d = mem_rdata ? vcfc_pkg::ST_PROBE : vcfc_pkg::ST_IDLE;
			end
			vcfc_pkg::ST_PROBE: begin
				if (face_q == vcfc_pkg::FACE_RIGHT) begin
					state_d = vcfc_pkg::ST_LAST;
				end
			end
			vcfc_pkg::ST_LAST: begin
				state_d = vcfc_pkg::ST_HAND;
			end
			vcfc_pkg::ST_HAND: begin
				job_valid = 1'b1;
				if (job_ready) begin
					state_d = vcfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vcfc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			ordinal_q  <= '0;
			pend_q     <= 1'b0;
			face_q     <= '0;
		end else begin
			if (state_q == vcfc_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (accept && op == vcfc_pkg::OP_RESTART) begin
				ordinal_q <= '0;
			end
			if (state_q == vcfc_pkg::ST_HAND && job_ready) begin
				ordinal_q <= ordinal_q + 1'b1;
			end
			pend_q <= (state_q == vcfc_pkg::ST_PROBE);
			if (state_q == vcfc_pkg::ST_PROBE) begin
				face_q <= face_q + 1'b1;
			end else begin
				face_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= ix;
			y_q <= iy;
			z_q <= iz;
		end
		pend_face_q <= face_q;
		pend_edge_q <= nb_edge;
		if (state_q == vcfc_pkg::ST_CENTER) begin
			mask_q <= '0;
		end else if (pend_q) begin
			mask_q[pend_face_q] <= pend_edge_q || !mem_rdata;
		end
	end

	assign job.face_open = mask_q;
	assign job.ordinal   = ordinal_q;

endmodule
`default_nettype wire

>>> sv/vcfc_emit.sv
// index emitter: six corner indices per open face through an output register
`default_nettype none
module vcfc_emit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           job_valid,
	input  wire vcfc_pkg::job_t                 job,
	output logic                                job_ready,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [vcfc_pkg::INDEX_W-1:0]        out_index,
	output logic                                out_last
);

	logic [vcfc_pkg::FACES-1:0]   mask_q;
	logic [vcfc_pkg::INDEX_W-1:0] base_q;
	logic [vcfc_pkg::FACE_W-1:0]  k_q;
	logic                         out_valid_q;
	logic [vcfc_pkg::INDEX_W-1:0] out_index_q;
	logic                         out_last_q;

	logic [vcfc_pkg::FACE_W-1:0]  face;
	logic [vcfc_pkg::FACES-1:0]   face_bit;
	logic                         slot_free;
	logic                         fire;
	logic                         face_done;

	// lowest open face still to go
	always_comb begin
		face = '0;
		for (int i = vcfc_pkg::FACES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				face = vcfc_pkg::FACE_W'(i);
			end
		end
	end

	assign face_bit  = vcfc_pkg::FACES'(1) << face;
	assign job_ready = (mask_q == '0);
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = (mask_q != '0) && slot_free;
	assign face_done = (k_q == vcfc_pkg::FACE_W'(vcfc_pkg::CORNERS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_valid && job_ready) begin
				mask_q <= job.face_open;
				k_q    <= '0;
			end else if (fire) begin
				if (face_done) begin
					k_q    <= '0;
					mask_q <= mask_q & ~face_bit;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// base is 24 times the ordinal, kept to the index width
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			base_q <= vcfc_pkg::INDEX_W'({job.ordinal, 4'b0000})
				+ vcfc_pkg::INDEX_W'({job.ordinal, 3'b000});
		end
		if (fire) begin
			out_index_q <= base_q + vcfc_pkg::INDEX_W'(vcfc_pkg::corner_off(face, k_q));
			out_last_q  <= face_done && ((mask_q & ~face_bit) == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

>>> sv/voxel_chunk_face_culler.sv
// top level of the voxel chunk face culler
//
// channel  dir  tdata                                   tuser          tlast
// s_*      in   [3:0] x, [7:4] y, [11:8] z, [12] solid  [1:0] op       -
// m_*      out  [16:0] vertex index                     -              last index
//
// a write or ordinal restart transaction, and a mesh transaction with an
// outside coordinate, leave the sequencer idle and ready for another; a mesh
// transaction reads the center voxel and, for a solid voxel, then its six
// neighbors, all on the single memory read port
// the indices of a solid voxel leave at one per cycle while m_tready is high,
// up to 36, and overlap the probing of the next voxel
// after reset a clearing pass writes air to the whole occupancy memory
// (2^(3*clog2(CHUNK_SIDE)) entries, 4096 by default), one entry per cycle, with
// s_tready low; a stalled m_tready holds the index and halts the emitter
`default_nettype none
module voxel_chunk_face_culler #(
	parameter int CHUNK_SIDE = vcfc_pkg::CHUNK_SIDE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [vcfc_pkg::IN_DATA_W-1:0]    s_tdata,  // coord_x, coord_y, coord_z, is_solid
	input  wire logic [vcfc_pkg::OP_W-1:0]         s_tuser,  // operation
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [vcfc_pkg::OUT_DATA_W-1:0]        m_tdata,  // vertex_index
	output logic                                   m_tlast   // last_index
);

	localparam int CW = $clog2(CHUNK_SIDE);
	localparam int AW = 3 * CW;

	// memory port between sequencer and occupancy store
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic          mem_rdata;

	// solid voxel handoff to the emitter
	logic           job_valid;
	logic           job_ready;
	vcfc_pkg::job_t job;

	logic [vcfc_pkg::INDEX_W-1:0] index;

	vcfc_ctrl #(
		.CHUNK_SIDE(CHUNK_SIDE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_x      (s_tdata[3:0]),
		.in_y      (s_tdata[7:4]),
		.in_z      (s_tdata[11:8]),
		.in_solid  (s_tdata[12]),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// voxel (x,y,z) sits at the packed address {z,y,x}
	vcfc_occ_mem #(
		.AW(AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	vcfc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (index),
		.out_last  (m_tlast)
	);

	// index padded to whole bytes
	assign m_tdata = vcfc_pkg::OUT_DATA_W'(index);

endmodule
`default_nettype wire

>>> dv/voxel_chunk_face_culler_test.sv
// self-checking testbench of the voxel chunk face culler: streamed commands against a face predictor
`default_nettype none
module voxel_chunk_face_culler_test;
	import vcfc_pkg::*;

	localparam int CHUNK = CHUNK_SIDE_DEF;
	localparam int VERTS_PER_VOXEL = 24;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_CMDS = 110;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               solid;
	} voxel_cmd_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               last;
	} vertex_rec_t;

	typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	voxel_cmd_t  cmd_queue[$];
	vertex_rec_t expected_vertices[$];

	// predictor state
	bit              solid_map [0:CHUNK*CHUNK*CHUNK-1];
	logic [ORD_W-1:0] ordinal_model = '0;

	// corner offsets per face, in emission order
	int corner_ofs [0:FACES-1][0:CORNERS-1] = '{
		'{0, 1, 2, 1, 3, 2},
		'{4, 6, 5, 5, 6, 7},
		'{8, 9, 10, 9, 11, 10},
		'{12, 14, 13, 13, 14, 15},
		'{16, 17, 18, 17, 19, 18},
		'{20, 22, 21, 21, 22, 23}
	};

	bit in_taken = 1'b0;
	int mismatch_count = 0;
	int results_seen = 0;
	int burst_left = 8;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int rx_left = 0;
	int rx_cycle = 0;
	rx_mode_t rx_mode = RX_STEADY;

	voxel_chunk_face_culler i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int voxel_addr(input int x, input int y, input int z);
		return (z * CHUNK + y) * CHUNK + x;
	endfunction

	// a face shows on the chunk edge or toward air
	function automatic bit face_open(input int f, input int x, input int y, input int z);
		int nx;
		int ny;
		int nz;
		nx = x;
		ny = y;
		nz = z;
		case (f)
			FACE_FRONT:  if (z == CHUNK - 1) return 1'b1; else nz = z + 1;
			FACE_BACK:   if (z == 0) return 1'b1; else nz = z - 1;
			FACE_TOP:    if (y == CHUNK - 1) return 1'b1; else ny = y + 1;
			FACE_BOTTOM: if (y == 0) return 1'b1; else ny = y - 1;
			FACE_LEFT:   if (x == 0) return 1'b1; else nx = x - 1;
			default:     if (x == CHUNK - 1) return 1'b1; else nx = x + 1;
		endcase
		return !solid_map[voxel_addr(nx, ny, nz)];
	endfunction

	task automatic predict_voxel_cmd(input voxel_cmd_t c);
		bit [FACES-1:0] open_mask;
		int last_face;
		int base;
		int f;
		int k;
		vertex_rec_t r;
		case (c.op)
			OP_RESTART: ordinal_model = '0;
			OP_WRITE:   solid_map[voxel_addr(c.x, c.y, c.z)] = c.solid;
			OP_MESH: begin
				if (solid_map[voxel_addr(c.x, c.y, c.z)]) begin
					last_face = -1;
					for (f = 0; f < FACES; f++) begin
						open_mask[f] = face_open(f, c.x, c.y, c.z);
						if (open_mask[f])
							last_face = f;
					end
					base = int'(ordinal_model) * VERTS_PER_VOXEL;
					for (f = 0; f < FACES; f++) begin
						if (open_mask[f]) begin
							for (k = 0; k < CORNERS; k++) begin
								r.index = INDEX_W'(base + corner_ofs[f][k]);
								r.last = (f == last_face) && (k == CORNERS - 1);
								expected_vertices = {expected_vertices, r};
							end
						end
					end
					ordinal_model = ordinal_model + 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void add_cmd(input logic [OP_W-1:0] op, input int x, input int y,
		input int z, input bit solid);
		voxel_cmd_t c;
		c.op = op;
		c.x = COORD_W'(x);
		c.y = COORD_W'(y);
		c.z = COORD_W'(z);
		c.solid = solid;
		cmd_queue = {cmd_queue, c};
	endfunction

	// mostly a dense cluster so neighbors matter, some edges, some anywhere
	function automatic int pick_coord();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return $urandom_range(4, 8);
		else if (sel < 17)
			return ($urandom_range(0, 1) == 1) ? CHUNK - 1 : 0;
		return $urandom_range(0, CHUNK - 1);
	endfunction

	// input side: accept transactions at the rising edge, check output transactions
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				in_taken = 1'b1;
				predict_voxel_cmd(voxel_cmd_t'({s_tuser, s_tdata[3:0], s_tdata[7:4],
					s_tdata[11:8], s_tdata[12]}));
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_vertices.size() == 0) begin
					report_mismatch($sformatf("unexpected index %0d", m_tdata));
				end else begin
					if (m_tdata !== OUT_DATA_W'(expected_vertices[0].index))
						report_mismatch($sformatf("vertex_index %0d, expected %0d",
							m_tdata, expected_vertices[0].index));
					if (m_tlast !== expected_vertices[0].last)
						report_mismatch($sformatf("last_index %0b, expected %0b at index %0d",
							m_tlast, expected_vertices[0].last, expected_vertices[0].index));
					void'(expected_vertices.pop_front());
				end
			end
		end
	end

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin : drive_proc
		voxel_cmd_t c;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					c = cmd_queue.pop_front();
					s_tdata <= {3'b000, c.solid, c.z, c.y, c.x};
					s_tuser <= c.op;
					s_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: one long hold-off, otherwise a randomly chosen stall pattern
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && results_seen >= 100) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(16, 96);
				end else begin
					rx_left--;
				end
				case (rx_mode)
					RX_STEADY: m_tready <= 1'b1;
					RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= (rx_cycle % 3 != 0);
				endcase
			end
		end
	end

	initial begin : stimulus_proc
		int i;
		int sel;
		// directed: air, unused op, corners, an enclosed voxel, restart, hidden faces
		add_cmd(OP_MESH, 0, 0, 0, 1'b0);
		add_cmd(OP_UNUSED, 15, 15, 15, 1'b1);
		add_cmd(OP_WRITE, 0, 0, 0, 1'b1);
		add_cmd(OP_MESH, 0, 0, 0, 1'b0);
		add_cmd(OP_WRITE, 15, 15, 15, 1'b1);
		add_cmd(OP_MESH, 15, 15, 15, 1'b0);
		add_cmd(OP_WRITE, 5, 5, 5, 1'b1);
		add_cmd(OP_WRITE, 5, 5, 6, 1'b1);
		add_cmd(OP_WRITE, 5, 5, 4, 1'b1);
		add_cmd(OP_WRITE, 5, 6, 5, 1'b1);
		add_cmd(OP_WRITE, 5, 4, 5, 1'b1);
		add_cmd(OP_WRITE, 4, 5, 5, 1'b1);
		add_cmd(OP_WRITE, 6, 5, 5, 1'b1);
		add_cmd(OP_MESH, 5, 5, 5, 1'b0);   // no face shows, ordinal still moves
		add_cmd(OP_MESH, 5, 5, 6, 1'b0);
		add_cmd(OP_RESTART, 0, 0, 0, 1'b0);
		add_cmd(OP_MESH, 0, 0, 0, 1'b0);
		add_cmd(OP_WRITE, 5, 5, 4, 1'b0);
		add_cmd(OP_MESH, 5, 5, 5, 1'b0);   // only the back face
		add_cmd(OP_WRITE, 5, 5, 4, 1'b1);
		// random mix of writes, meshes, restarts and unused ops around a cluster
		for (i = 0; i < RANDOM_CMDS; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45)
				add_cmd(OP_WRITE, pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(0, 9) < 7);
			else if (sel < 85)
				add_cmd(OP_MESH, pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(0, 1) == 1);
			else if (sel < 90)
				add_cmd(OP_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 15), $urandom_range(0, 1) == 1);
			else if (sel < 95)
				add_cmd(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 15), $urandom_range(0, 1) == 1);
			else
				add_cmd(OP_MESH, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 15), $urandom_range(0, 1) == 1);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() > 0 || s_tvalid)
			@(posedge clk);
		while (expected_vertices.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_vertices.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#12000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
